>>> src/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// shared constants for the fenwick prefix counter and its channels
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int SIZE   = 1024;
  localparam int ADDR_W = $clog2(SIZE);
  localparam int POS_W  = 11;
  localparam int CNT_W  = 32;
  localparam int IDX_W  = (ADDR_W + 2 > POS_W) ? ADDR_W + 2 : POS_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

endpackage

>>> src/fpc_if.sv
// ----------------------------------------------------------------------------
// fpc_in_if / fpc_out_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fpc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [fpc_pkg::POS_W-1:0]    position;

  modport source (output valid, output func, output position, input ready);
  modport sink   (input valid, input func, input position, output ready);
endinterface

interface fpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fpc_pkg::CNT_W-1:0]    prefix_count;

  modport source (output valid, output prefix_count, input ready);
  modport sink   (input valid, input prefix_count, output ready);
endinterface

>>> src/fenwick_prefix_counter.sv
// walk: each request visits n nodes of the tree (up to 11), one node read per cycle
//   on the single read port of the node memory
// throughput: one request at a time; a query result also waits on output stalls
// reset: synchronous, active low; then a clearing pass over all SIZE (1024)
//   nodes zeroes the node memory while no request is taken
// ----------------------------------------------------------------------------
// fenwick_prefix_counter
// binary indexed tree of saturating counters with insert and prefix query
// ----------------------------------------------------------------------------
module fenwick_prefix_counter (
  input  logic             clk,
  input  logic             rst_n,
  fpc_in_if.sink           in_ch,
  fpc_out_if.source        out_ch
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [fpc_pkg::IDX_W-1:0] SIZE_IDX = fpc_pkg::IDX_W'(fpc_pkg::SIZE);
  localparam logic [fpc_pkg::ADDR_W-1:0] LAST_ADDR = fpc_pkg::ADDR_W'(fpc_pkg::SIZE - 1);

  logic [fpc_pkg::CNT_W-1:0] mem [fpc_pkg::SIZE];

  logic [1:0]                  state_r, state_nxt;
  logic [fpc_pkg::ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                        op_r, op_nxt;
  logic [fpc_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [fpc_pkg::ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [fpc_pkg::CNT_W-1:0]   rd_data_r;
  logic [fpc_pkg::CNT_W-1:0]   sum_r, sum_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fpc_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;

  logic [fpc_pkg::IDX_W-1:0]   pos_ext;
  logic [fpc_pkg::IDX_W-1:0]   low_bit;
  logic [fpc_pkg::IDX_W-1:0]   idx_dec;
  logic                        issue;
  logic                        accept;
  logic                        mem_we;
  logic [fpc_pkg::ADDR_W-1:0]  mem_waddr;
  logic [fpc_pkg::CNT_W-1:0]   mem_wdata;
  logic [fpc_pkg::CNT_W:0]     sum_add;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.prefix_count = out_count_r;

  assign pos_ext = fpc_pkg::IDX_W'(in_ch.position);
  assign low_bit = idx_r & (~idx_r + fpc_pkg::IDX_W'(1));
  assign idx_dec = idx_r - fpc_pkg::IDX_W'(1);
  assign sum_add = {1'b0, sum_r} + {1'b0, rd_data_r};

  always_comb begin
    if (op_r == fpc_pkg::FUNC_QUERY) begin
      issue = (idx_r != '0);
    end else begin
      issue = (idx_r != '0) && (idx_r <= SIZE_IDX);
    end
  end

  // memory write port: clearing pass or read-modify-write of an insert
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_r;
    mem_wdata = (rd_data_r == fpc_pkg::COUNT_MAX) ? rd_data_r
                                                  : rd_data_r + fpc_pkg::CNT_W'(1);
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_WALK && op_r == fpc_pkg::FUNC_INSERT && rd_pend_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr_nxt];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + fpc_pkg::ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_ch.func;
          sum_nxt = '0;
          if (in_ch.func == fpc_pkg::FUNC_QUERY && pos_ext > SIZE_IDX) begin
            idx_nxt = SIZE_IDX;
          end else begin
            idx_nxt = pos_ext;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = idx_dec[fpc_pkg::ADDR_W-1:0];
          idx_nxt     = (op_r == fpc_pkg::FUNC_QUERY) ? idx_r - low_bit : idx_r + low_bit;
        end
        if (rd_pend_r && op_r == fpc_pkg::FUNC_QUERY) begin
          sum_nxt = sum_add[fpc_pkg::CNT_W] ? fpc_pkg::COUNT_MAX
                                            : sum_add[fpc_pkg::CNT_W-1:0];
        end
        if (!issue && !rd_pend_r) begin
          state_nxt = (op_r == fpc_pkg::FUNC_QUERY) ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    rd_addr_r   <= rd_addr_nxt;
    sum_r       <= sum_nxt;
    out_count_r <= out_count_nxt;
  end

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && op_r == fpc_pkg::FUNC_QUERY) |-> !mem_we)
    else $error("node memory written during a query walk");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_WALK))
    else $error("accepted request did not start a walk");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN && op_r == fpc_pkg::FUNC_QUERY))
    else $error("result raised outside a finished query");

  a_read_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_WALK))
    else $error("pending node read outside a walk");

endmodule
